FILE: hdl/assert_macros.svh
// assertion macros shared by the timer bank rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stb_pkg.sv
// types, constants and codes shared by the timer bank modules
`timescale 1ns / 1ps

package stb_pkg;

  // bank geometry
  localparam int NUM_TIMERS = 8;
  localparam int PRESCALE   = 2;

  // request and result field widths
  localparam int OP_W    = 2;
  localparam int TIDX_W  = 3;
  localparam int COUNT_W = 16;

  // derived widths
  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int NEXP_W = $clog2(NUM_TIMERS + 1);
  localparam int PH_W   = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // one request
  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [TIDX_W-1:0]         timer_index;
    logic signed [COUNT_W-1:0] count_value;
    logic                      notify_enable;
  } req_t;

  // one result
  typedef struct packed {
    logic              expired;
    logic [TIDX_W-1:0] expired_index;
    logic              last;
    logic              ticking;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic sweep;      // one step of the countdown pass
    logic scan;       // advance the expiry scan pointer
    logic emit_none;  // push the single no-expiry result of an acting tick
    logic emit_exp;   // push the expiry at the scan pointer
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;   // result register can take a new result
    logic acting;      // presented request is a tick that runs the pass
    logic sweep_last;  // final timer is being processed
    logic nexp_zero;   // no expiries left to report
    logic mask_bit;    // timer at the scan pointer expired with notify
    logic exp_last;    // one expiry left to report
  } sts_t;

endpackage

FILE: hdl/stb_ctrl.sv
// sequencing state machine for the timer bank
`timescale 1ns / 1ps

module stb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  stb_pkg::sts_t sts,
  output stb_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // requests are taken only when idle with room for a result
  assign req_stall = !((state == ST_IDLE) && sts.slot_free);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid && sts.slot_free) begin
          cmd.accept = 1'b1;
          if (sts.acting) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.nexp_zero) begin
          if (sts.slot_free) begin
            cmd.emit_none = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (!sts.mask_bit) begin
          cmd.scan = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit_exp = 1'b1;
          cmd.scan     = 1'b1;
          if (sts.exp_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/stb_datapath.sv
// count memory, prescaler, expiry mask and result register of the timer bank
`timescale 1ns / 1ps

module stb_datapath (
  input  logic          clk,
  input  logic          rst,
  input  stb_pkg::req_t req_data,
  input  stb_pkg::cmd_t cmd,
  output stb_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output stb_pkg::rsp_t rsp_data
);

  localparam logic [stb_pkg::IDX_W-1:0] IDX_LAST = stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1);
  localparam logic [stb_pkg::PH_W-1:0]  PH_LAST  = stb_pkg::PH_W'(stb_pkg::PRESCALE - 1);

  logic [stb_pkg::COUNT_W-1:0] mem [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::NUM_TIMERS-1:0] cnt_valid;
  logic [stb_pkg::NUM_TIMERS-1:0] notify_bits;
  logic [stb_pkg::NUM_TIMERS-1:0] exp_mask;

  logic [stb_pkg::IDX_W-1:0]   ptr, ptr_inc, rd_idx, req_idx, wr_addr;
  logic [stb_pkg::COUNT_W-1:0] rd_raw, cur_count, set_count, wr_data;
  logic                        rd_vld, rd_pend, wr_en;
  logic [stb_pkg::PH_W-1:0]    phase;
  logic                        tick_enable, running;
  logic [stb_pkg::NEXP_W-1:0]  nexp;
  logic                        in_range, is_tick, is_set, is_stop, acting;
  logic                        proc, dec, expire, sweep_last, load;
  stb_pkg::rsp_t               rsp_next;

  // request decode
  assign req_idx   = stb_pkg::IDX_W'(req_data.timer_index);
  assign in_range  = (32'(req_data.timer_index) < stb_pkg::NUM_TIMERS);
  assign is_tick   = (req_data.operation == stb_pkg::OP_TICK);
  assign is_set    = (req_data.operation == stb_pkg::OP_SET) && in_range;
  assign is_stop   = (req_data.operation == stb_pkg::OP_STOP) && in_range;
  assign set_count = req_data.count_value + stb_pkg::COUNT_W'(1);
  assign acting    = is_tick && tick_enable && (phase == PH_LAST);

  // countdown pass on the registered memory read
  assign cur_count  = rd_vld ? rd_raw : '0;
  assign proc       = cmd.sweep && rd_pend;
  assign dec        = proc && (cur_count > stb_pkg::COUNT_W'(1));
  assign expire     = proc && (cur_count == stb_pkg::COUNT_W'(1));
  assign sweep_last = rd_pend && (rd_idx == IDX_LAST);
  assign ptr_inc    = (ptr == IDX_LAST) ? '0 : ptr + stb_pkg::IDX_W'(1);

  // single write port shared by set, stop and the pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_idx;
    wr_data = '0;
    if (cmd.accept && is_set) begin
      wr_en   = 1'b1;
      wr_data = set_count;
    end else if (cmd.accept && is_stop) begin
      wr_en   = 1'b1;
    end else if (dec) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
      wr_data = cur_count - stb_pkg::COUNT_W'(1);
    end else if (expire) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[ptr];
  end

  // entry valid bits, an unwritten count reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        cnt_valid[wr_addr] <= 1'b1;
      end
      rd_vld <= cnt_valid[ptr];
    end
  end

  // notify bits
  always_ff @(posedge clk) begin
    if (rst) begin
      notify_bits <= '0;
    end else if (cmd.accept && is_set) begin
      notify_bits[req_idx] <= req_data.notify_enable;
    end else if (cmd.accept && is_stop) begin
      notify_bits[req_idx] <= 1'b0;
    end
  end

  // pointer, read tracking, pass summary and expiry bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_idx   <= '0;
      rd_pend  <= 1'b0;
      running  <= 1'b0;
      nexp     <= '0;
      exp_mask <= '0;
    end else begin
      rd_idx <= ptr;
      if (cmd.accept && acting) begin
        ptr      <= '0;
        rd_pend  <= 1'b0;
        running  <= 1'b0;
        nexp     <= '0;
        exp_mask <= '0;
      end else begin
        if (cmd.sweep) begin
          rd_pend <= 1'b1;
          ptr     <= sweep_last ? '0 : ptr_inc;
        end else if (cmd.scan) begin
          ptr <= ptr_inc;
        end
        if (dec) begin
          running <= 1'b1;
        end
        if (expire && notify_bits[rd_idx]) begin
          exp_mask[rd_idx] <= 1'b1;
          nexp             <= nexp + stb_pkg::NEXP_W'(1);
        end else if (cmd.emit_exp) begin
          nexp <= nexp - stb_pkg::NEXP_W'(1);
        end
      end
    end
  end

  // tick enable and prescaler phase
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_enable <= 1'b0;
      phase       <= '0;
    end else begin
      if (cmd.accept && is_tick && tick_enable) begin
        phase <= acting ? '0 : phase + stb_pkg::PH_W'(1);
      end
      if (cmd.accept && is_set && (set_count != '0)) begin
        tick_enable <= 1'b1;
      end else if (proc && sweep_last) begin
        tick_enable <= running || dec;
      end
    end
  end

  // next result
  always_comb begin
    rsp_next.expired       = 1'b0;
    rsp_next.expired_index = '0;
    rsp_next.last          = 1'b1;
    rsp_next.ticking       = tick_enable;
    if (cmd.emit_exp) begin
      rsp_next.expired       = 1'b1;
      rsp_next.expired_index = stb_pkg::TIDX_W'(ptr);
      rsp_next.last          = (nexp == stb_pkg::NEXP_W'(1));
    end else if (cmd.accept && is_set && (set_count != '0)) begin
      rsp_next.ticking = 1'b1;
    end
  end

  assign load = (cmd.accept && !acting) || cmd.emit_none || cmd.emit_exp;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= rsp_next;
    end
  end

  // status to the controller
  assign sts.slot_free  = !rsp_valid || !rsp_stall;
  assign sts.acting     = acting;
  assign sts.sweep_last = sweep_last;
  assign sts.nexp_zero  = (nexp == '0);
  assign sts.mask_bit   = exp_mask[ptr];
  assign sts.exp_last   = (nexp == stb_pkg::NEXP_W'(1));

endmodule

FILE: hdl/software_timer_bank.sv
// Bank of eight one-shot countdown timers run from a base tick. A set request loads a
// timer with count_value plus one and its notify bit, a stop request clears it, and a
// tick request, while ticking is enabled, runs a countdown pass on every second tick
// that reports each notifying timer reaching its end as one expiry result, in index
// order, with last on the final one. Set, stop and non-acting ticks give one result.
// An acting tick walks the count memory one timer per cycle through a registered
// read, then scans the expiry mask one timer per cycle up to the last expiry, pausing
// at each expiry while the result side stalls, or gives one result with no expiry
// when none is reported. Counts are cleared at reset through per-entry valid bits,
// so the bank takes requests straight after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module software_timer_bank (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  stb_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output stb_pkg::rsp_t rsp_data
);

  stb_pkg::cmd_t cmd;
  stb_pkg::sts_t sts;

  // sequencing
  stb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and result path
  stb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // a full, stalled result register holds off new requests
  `ASSERT_IMPL(a_full_holds_req, rsp_valid && rsp_stall, req_stall,
               "request taken while result blocked")
  // results without an expiry are always single and carry index zero
  `ASSERT_IMPL(a_plain_result, rsp_valid && !rsp_data.expired,
               rsp_data.last && (rsp_data.expired_index == '0), "malformed plain result")
  // no request is taken while the countdown pass is still running
  `ASSERT_NEXT(a_pass_busy, cmd.sweep, req_stall, "request taken during countdown pass")

endmodule
